// ===== rtl/gvm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gvm_pkg;

   localparam int MAX_WORDS = 4;
   localparam int MIN_WORDS = 2;
   localparam int WORD_BITS = 64;
   localparam int ROWS = MAX_WORDS * WORD_BITS;
   localparam int WIDX_BITS = $clog2(MAX_WORDS);
   localparam int ROW_BITS = $clog2(ROWS);
   localparam int BIT_IDX_BITS = $clog2(WORD_BITS);
   localparam int SIZE_BITS = 3;
   localparam int OP_BITS = 2;

   typedef enum logic [OP_BITS-1:0] {
      OP_WRITE  = 2'd0,
      OP_PRESET = 2'd1,
      OP_MUL    = 2'd2
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [ROW_BITS-1:0]    row;
      logic [WIDX_BITS-1:0]   word_index;
      logic [WORD_BITS-1:0]   data;
      logic                   clear_first;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0]   result_word;
      logic [WIDX_BITS-1:0]   result_index;
      logic                   last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_FLUSH,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic accept;
      logic bit_step;
      logic out_step;
   } cmd_type;

   typedef struct packed {
      logic mul_start;
      logic bit_done;
      logic last_word;
      logic out_last;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/gvm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gvm_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  gvm_pkg::req_type                req_data,
   input  logic                            csr_write,
   input  logic [gvm_pkg::SIZE_BITS-1:0]   csr_data,
   input  gvm_pkg::cmd_type                cmd,
   output gvm_pkg::status_type             status,
   output gvm_pkg::rsp_type                rsp_data
);

   logic [gvm_pkg::SIZE_BITS-1:0]    size_ff, size_in;
   logic [gvm_pkg::SIZE_BITS-1:0]    n_words;
   logic [gvm_pkg::SIZE_BITS-1:0]    n_minus_one;
   logic [gvm_pkg::WIDX_BITS-1:0]    last_idx;
   logic [gvm_pkg::WORD_BITS-1:0]    vec_ff, vec_in;
   logic [gvm_pkg::WIDX_BITS-1:0]    wi_ff, wi_in;
   logic [gvm_pkg::BIT_IDX_BITS-1:0] bit_cnt_ff, bit_cnt_in;
   logic                             apply_ff, apply_in;
   logic [gvm_pkg::WIDX_BITS-1:0]    out_idx_ff, out_idx_in;
   logic [gvm_pkg::WORD_BITS-1:0]    acc_ff [gvm_pkg::MAX_WORDS];
   logic [gvm_pkg::WORD_BITS-1:0]    acc_in [gvm_pkg::MAX_WORDS];
   logic [gvm_pkg::WORD_BITS-1:0]    rd_ff  [gvm_pkg::MAX_WORDS];
   logic [gvm_pkg::ROW_BITS-1:0]     rd_addr;
   logic                             mul_start;
   logic                             write_op;

   // Out-of-range size codes saturate to the nearest legal size.
   always_comb begin
      if (size_ff < gvm_pkg::SIZE_BITS'(gvm_pkg::MIN_WORDS)) begin
         n_words = gvm_pkg::SIZE_BITS'(gvm_pkg::MIN_WORDS);
      end else if (size_ff > gvm_pkg::SIZE_BITS'(gvm_pkg::MAX_WORDS)) begin
         n_words = gvm_pkg::SIZE_BITS'(gvm_pkg::MAX_WORDS);
      end else begin
         n_words = size_ff;
      end
   end

   assign n_minus_one = n_words - gvm_pkg::SIZE_BITS'(1);
   assign last_idx    = n_minus_one[gvm_pkg::WIDX_BITS-1:0];

   assign mul_start = (req_data.op == gvm_pkg::OP_MUL) &&
                      ({1'b0, req_data.word_index} < n_words);
   assign write_op  = cmd.accept && (req_data.op == gvm_pkg::OP_WRITE);

   // Row number of the bit under test: vector word index on top, bit index below.
   assign rd_addr = {wi_ff, bit_cnt_ff};

   // One bank per row word, so all words of a row are read together.
   for (genvar k = 0; k < gvm_pkg::MAX_WORDS; k++) begin : g_bank
      logic [gvm_pkg::WORD_BITS-1:0] mem [gvm_pkg::ROWS];

      always_ff @(posedge clock) begin
         if (write_op && (req_data.word_index == gvm_pkg::WIDX_BITS'(k))) begin
            mem[req_data.row] <= req_data.data;
         end
         rd_ff[k] <= mem[rd_addr];
      end
   end

   always_comb begin
      size_in = size_ff;
      if (csr_write) begin
         size_in = csr_data;
      end
   end

   always_comb begin
      vec_in     = vec_ff;
      wi_in      = wi_ff;
      bit_cnt_in = bit_cnt_ff;
      out_idx_in = out_idx_ff;
      if (cmd.accept) begin
         vec_in     = req_data.data;
         wi_in      = req_data.word_index;
         bit_cnt_in = '0;
         out_idx_in = '0;
      end
      if (cmd.bit_step) begin
         vec_in     = vec_ff >> 1;
         bit_cnt_in = bit_cnt_ff + gvm_pkg::BIT_IDX_BITS'(1);
      end
      if (cmd.out_step) begin
         out_idx_in = out_idx_ff + gvm_pkg::WIDX_BITS'(1);
      end
   end

   // The row read issued now returns next cycle, so the select bit is delayed to match.
   assign apply_in = cmd.bit_step && vec_ff[0];

   always_comb begin
      for (int k = 0; k < gvm_pkg::MAX_WORDS; k++) begin
         acc_in[k] = acc_ff[k];
      end
      if (cmd.accept && (req_data.op == gvm_pkg::OP_PRESET)) begin
         acc_in[req_data.word_index] = req_data.data;
      end else if (cmd.accept && mul_start && req_data.clear_first &&
                   (req_data.word_index == '0)) begin
         for (int k = 0; k < gvm_pkg::MAX_WORDS; k++) begin
            acc_in[k] = '0;
         end
      end
      if (apply_ff) begin
         for (int k = 0; k < gvm_pkg::MAX_WORDS; k++) begin
            if (gvm_pkg::SIZE_BITS'(k) < n_words) begin
               acc_in[k] = acc_ff[k] ^ rd_ff[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= gvm_pkg::SIZE_BITS'(gvm_pkg::MAX_WORDS);
         apply_ff <= 1'b0;
         for (int k = 0; k < gvm_pkg::MAX_WORDS; k++) begin
            acc_ff[k] <= '0;
         end
      end else begin
         size_ff  <= size_in;
         apply_ff <= apply_in;
         for (int k = 0; k < gvm_pkg::MAX_WORDS; k++) begin
            acc_ff[k] <= acc_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      vec_ff     <= vec_in;
      wi_ff      <= wi_in;
      bit_cnt_ff <= bit_cnt_in;
      out_idx_ff <= out_idx_in;
   end

   assign status.mul_start = mul_start;
   assign status.bit_done  = (bit_cnt_ff == '1);
   assign status.last_word = (wi_ff == last_idx);
   assign status.out_last  = (out_idx_ff == last_idx);

   assign rsp_data.result_word  = acc_ff[out_idx_ff];
   assign rsp_data.result_index = out_idx_ff;
   assign rsp_data.last         = (out_idx_ff == last_idx);

endmodule

`default_nettype wire

// ===== rtl/gvm_control.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gvm_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  gvm_pkg::status_type   status,
   output gvm_pkg::cmd_type      cmd
);

   gvm_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gvm_pkg::ST_IDLE: begin
            if (req_valid && status.mul_start) begin
               state_in = gvm_pkg::ST_MUL;
            end
         end
         gvm_pkg::ST_MUL: begin
            if (status.bit_done) begin
               state_in = gvm_pkg::ST_FLUSH;
            end
         end
         gvm_pkg::ST_FLUSH: begin
            // The last row is folded in during this cycle.
            state_in = status.last_word ? gvm_pkg::ST_OUT : gvm_pkg::ST_IDLE;
         end
         gvm_pkg::ST_OUT: begin
            if (!rsp_stall && status.out_last) begin
               state_in = gvm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gvm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall    = 1'b1;
      rsp_valid    = 1'b0;
      cmd.accept   = 1'b0;
      cmd.bit_step = 1'b0;
      cmd.out_step = 1'b0;
      unique case (state_ff)
         gvm_pkg::ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         gvm_pkg::ST_MUL: begin
            cmd.bit_step = 1'b1;
         end
         gvm_pkg::ST_FLUSH: begin
         end
         gvm_pkg::ST_OUT: begin
            rsp_valid    = 1'b1;
            cmd.out_step = !rsp_stall;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gvm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_intake_while_output: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while a result word is pending");

   a_flush_follows_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gvm_pkg::ST_FLUSH) |-> ($past(state_ff) == gvm_pkg::ST_MUL))
      else $error("flush cycle without a preceding multiply pass");

   a_stalled_output_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result word dropped while stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/gf2_vector_matrix_multiply.sv =====
`timescale 1ns / 1ps
`default_nettype none

// GF(2) vector-by-matrix multiplier for 128, 192 or 256 bit squares, size set by the csr
// word (2, 3 or 4 64-bit words). Matrix writes, accumulator presets, unknown ops and vector
// words beyond the size are each taken in the idle state. A vector word is taken, then one
// row of the matrix is read per cycle from four 256 x 64 banks, one bank per row word, for
// each of the 64 vector bits, and a flush state lets the last read land. After the vector
// word whose index is size-1 the block returns size product words, one per cycle when not
// stalled, and takes no new input word until the last of them is delivered.
module gf2_vector_matrix_multiply (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  gvm_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output gvm_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [gvm_pkg::SIZE_BITS-1:0]   csr_data
);

   gvm_pkg::cmd_type    cmd;
   gvm_pkg::status_type status;

   assign csr_ready = 1'b1;

   gvm_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gvm_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
